>>> rtl/sle_pkg.sv
// shared types and constants of the sequential list engine
package sle_pkg;

	localparam int KEY_WIDTH   = 32;
	localparam int DATA_WIDTH  = 32;
	localparam int POS_WIDTH   = 5;
	localparam int KIND_WIDTH  = 3;
	localparam int COUNT_WIDTH = 5;

	typedef enum logic [KIND_WIDTH-1:0] {
		OP_INS_HEAD,
		OP_INS_AT,
		OP_INS_TAIL,
		OP_REM_HEAD,
		OP_REM_AT,
		OP_REM_TAIL,
		OP_READ,
		OP_FIND
	} op_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SEL,
		S_OUT
	} sle_state_t;

	typedef enum logic [1:0] {
		ACT_KEEP,
		ACT_TAKE_LEFT,
		ACT_TAKE_RIGHT,
		ACT_LOAD_NEW
	} cell_act_t;

endpackage

>>> rtl/sle_if.sv
// request and response channel interfaces of the sequential list engine
interface sle_req_if import sle_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_WIDTH-1:0] kind;
	logic [POS_WIDTH-1:0]  position;
	logic [KEY_WIDTH-1:0]  entry_key;
	logic [DATA_WIDTH-1:0] entry_payload;

	modport source (output valid, kind, position, entry_key, entry_payload, input ready);
	modport sink (input valid, kind, position, entry_key, entry_payload, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic [KEY_WIDTH-1:0]   out_key;
	logic [DATA_WIDTH-1:0]  out_payload;
	logic [COUNT_WIDTH-1:0] entry_count;
	logic                   is_full;
	logic                   is_empty;

	modport source (output valid, ok, out_key, out_payload, entry_count, is_full, is_empty,
		input ready);
	modport sink (input valid, ok, out_key, out_payload, entry_count, is_full, is_empty,
		output ready);
endinterface

>>> rtl/sle_cell.sv
// one list slot: holds an entry, shifts with its neighbors and compares its key
module sle_cell import sle_pkg::*; #(
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                     clk,
	input  cell_act_t                act,
	input  logic [KEY_WIDTH-1:0]     left_key,
	input  logic [PAYLOAD_WIDTH-1:0] left_payload,
	input  logic [KEY_WIDTH-1:0]     right_key,
	input  logic [PAYLOAD_WIDTH-1:0] right_payload,
	input  logic [KEY_WIDTH-1:0]     new_key,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic [KEY_WIDTH-1:0]     cmp_key,
	output logic [KEY_WIDTH-1:0]     key,
	output logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     match
);

	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;

	always_ff @(posedge clk) begin
		case (act)
			ACT_TAKE_LEFT: begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
			ACT_TAKE_RIGHT: begin
				key_q     <= right_key;
				payload_q <= right_payload;
			end
			ACT_LOAD_NEW: begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
			default: begin
				key_q     <= key_q;
				payload_q <= payload_q;
			end
		endcase
	end

	assign key     = key_q;
	assign payload = payload_q;
	assign match   = (key_q == cmp_key);

endmodule

>>> rtl/sequential_list_engine.sv
// top level of the sequential list engine: control, cell row and result register
// a request word is accepted only in idle, after the previous one has run the three-step
// sequence over the cell row (shift and compare, first-hit select, gather); the result
// register loads in the gather step, which waits while a held result is not yet taken
// reset: entry count cleared, slot contents undefined until written, no clearing pass
module sequential_list_engine import sle_pkg::*; #(
	parameter int CAPACITY      = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	sle_req_if.sink  req,
	sle_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = CW + POS_WIDTH;

	sle_state_t state_q, state_d;

	op_kind_t                 kind_q;
	logic [POS_WIDTH-1:0]     pos_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic [CW-1:0]            count_q;
	logic                     ok_q;
	logic [CAPACITY-1:0]      hit_q;
	logic [CAPACITY-1:0]      sel_q;

	logic                     rsp_valid_q;
	logic                     rsp_ok_q;
	logic [KEY_WIDTH-1:0]     rsp_key_q;
	logic [DATA_WIDTH-1:0]    rsp_payload_q;
	logic [COUNT_WIDTH-1:0]   rsp_count_q;
	logic                     rsp_full_q;
	logic                     rsp_empty_q;

	logic [63:0]              payload_wide;
	logic [KEY_WIDTH-1:0]     cell_key [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];
	logic [CAPACITY-1:0]      cell_match;
	cell_act_t                cell_act [CAPACITY];

	logic [EW-1:0]            pos_e;
	logic [EW-1:0]            cnt_e;
	logic [EW-1:0]            idx_e;
	logic                     is_ins;
	logic                     is_rem;
	logic                     is_read;
	logic                     is_find;
	logic                     ins_ok;
	logic                     rem_ok;
	logic                     read_ok;
	logic                     load_out;

	logic [KEY_WIDTH-1:0]     gather_key;
	logic [PAYLOAD_WIDTH-1:0] gather_payload;
	logic [63:0]              gather_wide;

	assign req.ready    = (state_q == S_IDLE);
	assign payload_wide = 64'(req.entry_payload);
	assign load_out     = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	// operation decode
	assign pos_e = EW'(pos_q);
	assign cnt_e = EW'(count_q);

	always_comb begin
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		is_read = 1'b0;
		is_find = 1'b0;
		idx_e   = '0;
		case (kind_q)
			OP_INS_HEAD: begin
				is_ins = 1'b1;
			end
			OP_INS_AT: begin
				is_ins = 1'b1;
				idx_e  = pos_e - EW'(1);
			end
			OP_INS_TAIL: begin
				is_ins = 1'b1;
				idx_e  = cnt_e;
			end
			OP_REM_HEAD: begin
				is_rem = 1'b1;
			end
			OP_REM_AT: begin
				is_rem = 1'b1;
				idx_e  = pos_e - EW'(1);
			end
			OP_REM_TAIL: begin
				is_rem = 1'b1;
				idx_e  = cnt_e - EW'(1);
			end
			OP_READ: begin
				is_read = 1'b1;
				idx_e   = pos_e - EW'(1);
			end
			default: begin
				is_find = 1'b1;
			end
		endcase
	end

	// position zero wraps the index to all ones and fails every range check
	assign ins_ok  = is_ins && (cnt_e < EW'(CAPACITY)) && (idx_e <= cnt_e);
	assign rem_ok  = is_rem && (idx_e < cnt_e);
	assign read_ok = is_read && (idx_e < cnt_e);

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_WIDTH-1:0]     l_key, r_key;
		logic [PAYLOAD_WIDTH-1:0] l_payload, r_payload;

		if (i == 0) begin : g_first
			assign l_key     = cell_key[i];
			assign l_payload = cell_payload[i];
		end else begin : g_mid_l
			assign l_key     = cell_key[i-1];
			assign l_payload = cell_payload[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_key     = cell_key[i];
			assign r_payload = cell_payload[i];
		end else begin : g_mid_r
			assign r_key     = cell_key[i+1];
			assign r_payload = cell_payload[i+1];
		end

		always_comb begin
			cell_act[i] = ACT_KEEP;
			if (state_q == S_CMP) begin
				if (ins_ok) begin
					if (EW'(i) > idx_e) begin
						cell_act[i] = ACT_TAKE_LEFT;
					end else if (EW'(i) == idx_e) begin
						cell_act[i] = ACT_LOAD_NEW;
					end
				end else if (rem_ok && (EW'(i) >= idx_e)) begin
					cell_act[i] = ACT_TAKE_RIGHT;
				end
			end
		end

		sle_cell #(
			.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
		) u_cell (
			.clk          (clk),
			.act          (cell_act[i]),
			.left_key     (l_key),
			.left_payload (l_payload),
			.right_key    (r_key),
			.right_payload(r_payload),
			.new_key      (key_q),
			.new_payload  (payload_q),
			.cmp_key      (key_q),
			.key          (cell_key[i]),
			.payload      (cell_payload[i]),
			.match        (cell_match[i])
		);
	end

	// gather the selected slot
	always_comb begin
		gather_key     = '0;
		gather_payload = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			gather_key     = gather_key | (cell_key[i] & {KEY_WIDTH{sel_q[i]}});
			gather_payload = gather_payload | (cell_payload[i] & {PAYLOAD_WIDTH{sel_q[i]}});
		end
	end

	assign gather_wide = 64'(gather_payload);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_SEL;
			end
			S_SEL: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_CMP) begin
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (rem_ok) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q    <= op_kind_t'(req.kind);
			pos_q     <= req.position;
			key_q     <= req.entry_key;
			payload_q <= payload_wide[PAYLOAD_WIDTH-1:0];
		end
		if (state_q == S_CMP) begin
			ok_q <= ins_ok || rem_ok;
			for (int i = 0; i < CAPACITY; i++) begin
				hit_q[i] <= (read_ok && (EW'(i) == idx_e)) ||
					(is_find && cell_match[i] && (EW'(i) < cnt_e));
			end
		end
		if (state_q == S_SEL) begin
			sel_q <= hit_q & (~hit_q + CAPACITY'(1));
			if (is_read || is_find) begin
				ok_q <= |hit_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_ok_q      <= ok_q;
			rsp_key_q     <= gather_key;
			rsp_payload_q <= gather_wide[DATA_WIDTH-1:0];
			rsp_count_q   <= COUNT_WIDTH'(count_q);
			rsp_full_q    <= (count_q == CW'(CAPACITY));
			rsp_empty_q   <= (count_q == '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.out_key     = rsp_key_q;
	assign rsp.out_payload = rsp_payload_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_full     = rsp_full_q;
	assign rsp.is_empty    = rsp_empty_q;

endmodule
